/* sv/pev_pkg.sv */
// ----------------------------------------------------------------------------
// pev_pkg
// Shared constants, register indexes and pipeline word types of the
// polynomial evaluate / derivative unit.
// ----------------------------------------------------------------------------
package pev_pkg;

	// polynomial size and number format
	localparam int MAX_DEGREE = 6;
	localparam int FRAC_BITS  = 8;
	localparam int COEF_W     = 16;
	localparam int VAL_W      = 32;
	localparam int DEG_W      = 3;
	localparam int PROD_W     = VAL_W + COEF_W;
	localparam int SUM_W      = PROD_W + 1;

	// configuration port
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 4'd1;

	// opcodes
	localparam logic OP_EVAL  = 1'b0;
	localparam logic OP_DERIV = 1'b1;

	// input queue depth
	localparam int FIFO_DEPTH = 2;

	typedef logic signed [COEF_W-1:0] coef_t;

	// one queued input word
	typedef struct packed {
		logic                     opcode;
		logic signed [COEF_W-1:0] point;
	} pev_req_t;

	// one micro-op in flight (one per result)
	typedef struct packed {
		logic                     deriv;
		logic signed [COEF_W-1:0] x;
		logic signed [VAL_W-1:0]  acc;
		logic [DEG_W-1:0]         power;
		logic                     last;
		logic                     sat;
	} pev_uop_t;

	// micro-op after the multiply half of a horner step
	typedef struct packed {
		logic                     deriv;
		logic signed [COEF_W-1:0] x;
		logic signed [PROD_W-1:0] prod;
		logic [DEG_W-1:0]         power;
		logic                     last;
		logic                     sat;
	} pev_mul_t;

endpackage

/* sv/pev_front.sv */
// ----------------------------------------------------------------------------
// pev_front
// Input side: accepts request words into a short queue that decouples the
// input handshake from the issue logic.
// ----------------------------------------------------------------------------
module pev_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic signed [pev_pkg::COEF_W-1:0] point,
	output logic                            head_valid,
	output pev_pkg::pev_req_t               head,
	input  logic                            pop
);
	import pev_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	pev_req_t         mem_q [0:FIFO_DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             do_pop;

	// handshake
	assign in_ready   = (cnt_q != CNT_W'(FIFO_DEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (cnt_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{opcode: opcode, point: point};
		end
	end

endmodule

/* sv/pev_issue.sv */
// ----------------------------------------------------------------------------
// pev_issue
// Classifies the queue head and issues micro-ops into the pipeline: one for
// an evaluate word, one per derivative coefficient for a derivative word.
// ----------------------------------------------------------------------------
module pev_issue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  pev_pkg::pev_req_t             head,
	output logic                          pop,
	input  pev_pkg::coef_t                coef [0:pev_pkg::MAX_DEGREE],
	input  logic [pev_pkg::DEG_W-1:0]     deg,
	input  logic                          adv,
	output logic                          uop_valid,
	output pev_pkg::pev_uop_t             uop
);
	import pev_pkg::*;

	localparam int DPROD_W = COEF_W + DEG_W + 1;

	logic               busy_q;
	logic [DEG_W-1:0]   pow_q;
	logic [DEG_W-1:0]   p;
	logic signed [DPROD_W-1:0] dprod;
	logic               is_deriv;
	logic               deriv_zero;
	logic               final_uop;

	assign is_deriv   = (head.opcode == OP_DERIV);
	assign deriv_zero = (deg == '0);
	assign p          = busy_q ? pow_q : deg;
	assign dprod      = $signed({1'b0, p}) * coef[p];
	assign final_uop  = !is_deriv || deriv_zero || (p == DEG_W'(1));
	assign uop_valid  = head_valid;
	assign pop        = head_valid && adv && final_uop;

	// micro-op build
	always_comb begin
		uop       = '0;
		uop.x     = head.point;
		uop.deriv = is_deriv;
		if (!is_deriv) begin
			uop.acc   = {{(VAL_W-COEF_W){coef[MAX_DEGREE][COEF_W-1]}}, coef[MAX_DEGREE]};
			uop.power = '0;
			uop.last  = 1'b1;
		end else if (deriv_zero) begin
			uop.acc   = '0;
			uop.power = '0;
			uop.last  = 1'b1;
		end else begin
			uop.acc   = {{(VAL_W-DPROD_W){dprod[DPROD_W-1]}}, dprod};
			uop.power = p - 1'b1;
			uop.last  = (p == DEG_W'(1));
		end
	end

	// derivative power counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pow_q  <= '0;
		end else if (head_valid && adv) begin
			if (final_uop) begin
				busy_q <= 1'b0;
			end else begin
				busy_q <= 1'b1;
				pow_q  <= p - 1'b1;
			end
		end
	end

endmodule

/* sv/pev_pipe.sv */
// ----------------------------------------------------------------------------
// pev_pipe
// Horner pipeline: one multiply stage and one shift / add / saturate stage
// per step; derivative micro-ops pass through unchanged. The last stage is
// the output register.
// ----------------------------------------------------------------------------
module pev_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              uop_valid,
	input  pev_pkg::pev_uop_t                 uop,
	output logic                              adv,
	input  pev_pkg::coef_t                    coef [0:pev_pkg::MAX_DEGREE],
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pev_pkg::VAL_W-1:0]  value,
	output logic [pev_pkg::DEG_W-1:0]         term_power,
	output logic                              last,
	output logic                              saturated
);
	import pev_pkg::*;

	localparam int N = MAX_DEGREE;

	pev_uop_t stg_s  [0:N];
	logic     vstg_s [0:N];
	pev_mul_t mul_s  [1:N];
	logic     vmul_s [1:N];

	pev_mul_t mul_n  [1:N];
	pev_uop_t add_n  [1:N];

	// whole pipeline moves when the output slot is free
	assign adv = !vstg_s[N] || out_ready;

	// multiply half of each step
	always_comb begin
		for (int j = 1; j <= N; j++) begin
			mul_n[j].deriv = stg_s[j-1].deriv;
			mul_n[j].x     = stg_s[j-1].x;
			mul_n[j].power = stg_s[j-1].power;
			mul_n[j].last  = stg_s[j-1].last;
			mul_n[j].sat   = stg_s[j-1].sat;
			if (stg_s[j-1].deriv) begin
				mul_n[j].prod = {{(PROD_W-VAL_W){stg_s[j-1].acc[VAL_W-1]}}, stg_s[j-1].acc};
			end else begin
				mul_n[j].prod = $signed(stg_s[j-1].acc) * $signed(stg_s[j-1].x);
			end
		end
	end

	// shift, add next coefficient, clip to 32 bits
	always_comb begin
		for (int j = 1; j <= N; j++) begin
			logic signed [PROD_W-1:0] shifted;
			logic signed [SUM_W-1:0]  sum;
			logic                     ovf;
			shifted = $signed(mul_s[j].prod) >>> FRAC_BITS;
			sum     = $signed({shifted[PROD_W-1], shifted})
				+ $signed({{(SUM_W-COEF_W){coef[N-j][COEF_W-1]}}, coef[N-j]});
			ovf     = (sum[SUM_W-1:VAL_W-1] != '0) && (sum[SUM_W-1:VAL_W-1] != '1);
			add_n[j].deriv = mul_s[j].deriv;
			add_n[j].x     = mul_s[j].x;
			add_n[j].power = mul_s[j].power;
			add_n[j].last  = mul_s[j].last;
			if (mul_s[j].deriv) begin
				add_n[j].acc = mul_s[j].prod[VAL_W-1:0];
				add_n[j].sat = mul_s[j].sat;
			end else if (ovf) begin
				add_n[j].acc = sum[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
					: {1'b0, {(VAL_W-1){1'b1}}};
				add_n[j].sat = 1'b1;
			end else begin
				add_n[j].acc = sum[VAL_W-1:0];
				add_n[j].sat = mul_s[j].sat;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= N; j++) begin
				vstg_s[j] <= 1'b0;
			end
			for (int j = 1; j <= N; j++) begin
				vmul_s[j] <= 1'b0;
			end
		end else if (adv) begin
			vstg_s[0] <= uop_valid;
			for (int j = 1; j <= N; j++) begin
				vmul_s[j] <= vstg_s[j-1];
				vstg_s[j] <= vmul_s[j];
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			stg_s[0] <= uop;
			for (int j = 1; j <= N; j++) begin
				mul_s[j] <= mul_n[j];
				stg_s[j] <= add_n[j];
			end
		end
	end

	assign out_valid  = vstg_s[N];
	assign value      = stg_s[N].acc;
	assign term_power = stg_s[N].power;
	assign last       = stg_s[N].last;
	assign saturated  = stg_s[N].sat;

endmodule

/* sv/polynomial_eval_and_derivative_unit.sv */
// ----------------------------------------------------------------------------
// polynomial_eval_and_derivative_unit
// Q8.8 polynomial of degree up to six: evaluates at a point by Horner's rule
// or lists the derivative's coefficients from the highest power down.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_ready  | opcode, point
//  out     | output    | out_valid / out_ready| value, term_power, last, saturated
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An evaluate word issues one micro-op; a derivative word issues one per power
// from degree down to one (one at degree zero), set by the issue sequencer.
// From input accept to output valid a word passes the queue, the issue
// register, then a multiply and an add stage per Horner step.
// A stall on out_ready holds the whole pipeline; the two-word input queue
// keeps accepting until full. cfg_ready is always high.
// Reset clears the registers to zero and empties queue and pipeline.
// ----------------------------------------------------------------------------
module polynomial_eval_and_derivative_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic signed [pev_pkg::COEF_W-1:0]   point,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pev_pkg::VAL_W-1:0]    value,
	output logic [pev_pkg::DEG_W-1:0]           term_power,
	output logic                                last,
	output logic                                saturated,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pev_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pev_pkg::COEF_W-1:0]          cfg_data
);
	import pev_pkg::*;

	logic [DEG_W-1:0] degree_q;
	coef_t            coef_q   [0:MAX_DEGREE];
	coef_t            coef_use [0:MAX_DEGREE];
	logic [DEG_W-1:0] deg_used;

	logic      head_valid;
	pev_req_t  head;
	logic      pop;
	logic      adv;
	logic      uop_valid;
	pev_uop_t  uop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			for (int k = 0; k <= MAX_DEGREE; k++) begin
				coef_q[k] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DEGREE) begin
				degree_q <= cfg_data[DEG_W-1:0];
			end
			for (int k = 0; k <= MAX_DEGREE; k++) begin
				if (cfg_index == REG_COEF0 + CFG_IDX_W'(k)) begin
					coef_q[k] <= cfg_data;
				end
			end
		end
	end

	// clamp degree, zero the coefficients above it
	assign deg_used = (degree_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_q;

	always_comb begin
		for (int k = 0; k <= MAX_DEGREE; k++) begin
			coef_use[k] = (DEG_W'(k) <= deg_used) ? coef_q[k] : '0;
		end
	end

	pev_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.point      (point),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	pev_issue u_issue (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.coef       (coef_use),
		.deg        (deg_used),
		.adv        (adv),
		.uop_valid  (uop_valid),
		.uop        (uop)
	);

	pev_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.uop_valid  (uop_valid),
		.uop        (uop),
		.adv        (adv),
		.coef       (coef_use),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.term_power (term_power),
		.last       (last),
		.saturated  (saturated)
	);

endmodule

/* sv/pev_checker.sv */
// ----------------------------------------------------------------------------
// pev_checker
// Port-level checks of the polynomial unit, bound to the top level.
// ----------------------------------------------------------------------------
module pev_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [pev_pkg::VAL_W-1:0]    value,
	input  logic [pev_pkg::DEG_W-1:0]           term_power,
	input  logic                                last,
	input  logic                                saturated
);
	import pev_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(term_power)
			&& $stable(last) && $stable(saturated))
		else $error("result word changed while stalled");

	// clipping only happens on evaluate results, which carry power zero
	a_sat_eval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && term_power != '0 |-> !saturated)
		else $error("saturated set on a derivative coefficient");

	// only the power-zero coefficient closes a derivative list
	a_last_pow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && term_power != '0 |-> !last)
		else $error("last set before the final derivative coefficient");

endmodule

bind polynomial_eval_and_derivative_unit pev_checker u_pev_checker (.*);

/* tb/tb_polynomial_eval_and_derivative_unit.sv */
// ----------------------------------------------------------------------------
// tb_polynomial_eval_and_derivative_unit
// Self-checking bench for the Q8.8 polynomial evaluate / derivative unit.
// A directed table covers reset values, degree zero, the degree clamp,
// saturation at both rails, floor rounding and ignored register indexes.
// Random phases then reload the polynomial with a fresh degree and
// coefficients, and stream evaluate and derivative words. The sender and
// the receiver stall at random. Every result word is checked against a value
// from the directed table or an in-bench Horner / derivative calculator.
// ----------------------------------------------------------------------------
module tb_polynomial_eval_and_derivative_unit;
	import pev_pkg::*;

	localparam int REG_LAST = REG_COEF0 + MAX_DEGREE;
	localparam logic [CFG_IDX_W-1:0] REG_BEYOND_FIRST = CFG_IDX_W'(REG_LAST + 1);
	localparam logic [CFG_IDX_W-1:0] REG_BEYOND_LAST  = '1;
	localparam longint VAL_MAX = 2147483647;
	localparam longint VAL_MIN = -VAL_MAX - 1;
	localparam int N_PHASES        = 12;
	localparam int WORDS_PER_PHASE = 29;
	localparam int TAIL_CYCLES     = 32;

	// one expected result word
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [DEG_W-1:0]        power;
		logic                    last;
		logic                    sat;
	} poly_result_t;

	// one row of the directed table: a register write or an input word
	typedef struct packed {
		logic                    is_cfg;
		logic [CFG_IDX_W-1:0]    idx;
		logic [COEF_W-1:0]       data;
		logic                    op;
		coef_t                   pt;
		logic                    typed;
		logic signed [VAL_W-1:0] val;
		logic                    sat;
	} plan_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    opcode;
	coef_t                   point;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [VAL_W-1:0] value;
	logic [DEG_W-1:0]        term_power;
	logic                    last;
	logic                    saturated;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [COEF_W-1:0]       cfg_data;

	// shadow of the polynomial registers
	logic [DEG_W-1:0] cfg_degree;
	coef_t            cfg_coef [0:MAX_DEGREE];

	poly_result_t poly_results_due [$];
	plan_row_t    plan [$];
	bit           calm;
	int           n_failures;
	int           n_eval_words;
	int           n_deriv_words;
	int           n_result_words;
	int           n_sat_words;

	polynomial_eval_and_derivative_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.point      (point),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.term_power (term_power),
		.last       (last),
		.saturated  (saturated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	initial begin
		#400000;
		$display("tb_polynomial_eval_and_derivative_unit: FAIL");
		$finish;
	end

	// register write as seen by the shadow copy
	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [COEF_W-1:0] data);
		if (idx == REG_DEGREE) begin
			cfg_degree = data[DEG_W-1:0];
		end else if (idx >= REG_COEF0 && idx <= REG_LAST) begin
			cfg_coef[idx - REG_COEF0] = data;
		end
	endfunction

	// queue the result words one input word produces
	function automatic void compute_poly_results(input logic op, input coef_t x);
		int           d;
		longint       acc;
		logic         sat;
		poly_result_t r;
		d = (cfg_degree > MAX_DEGREE) ? MAX_DEGREE : int'(cfg_degree);
		if (op == OP_EVAL) begin
			// horner: multiply, floor shift, add next coefficient, clip
			acc = longint'(cfg_coef[d]);
			sat = 1'b0;
			for (int k = d - 1; k >= 0; k--) begin
				acc = ((acc * longint'(x)) >>> FRAC_BITS) + longint'(cfg_coef[k]);
				if (acc > VAL_MAX) begin
					acc = VAL_MAX;
					sat = 1'b1;
				end else if (acc < VAL_MIN) begin
					acc = VAL_MIN;
					sat = 1'b1;
				end
			end
			r = '{value: acc[VAL_W-1:0], power: '0, last: 1'b1, sat: sat};
			poly_results_due.push_back(r);
		end else if (d == 0) begin
			// constant polynomial: a single zero
			r = '{value: '0, power: '0, last: 1'b1, sat: 1'b0};
			poly_results_due.push_back(r);
		end else begin
			for (int p = d; p >= 1; p--) begin
				r.value = p * cfg_coef[p];
				r.power = DEG_W'(p - 1);
				r.last  = (p == 1);
				r.sat   = 1'b0;
				poly_results_due.push_back(r);
			end
		end
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [COEF_W-1:0] data);
		plan_row_t r;
		r        = '0;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		return r;
	endfunction

	function automatic plan_row_t word_row(input logic op, input coef_t pt);
		plan_row_t r;
		r    = '0;
		r.op = op;
		r.pt = pt;
		return r;
	endfunction

	// word whose single result is obvious: term_power 0, last 1
	function automatic plan_row_t known_row(input logic op, input coef_t pt,
			input logic signed [VAL_W-1:0] val, input logic sat);
		plan_row_t r;
		r       = word_row(op, pt);
		r.typed = 1'b1;
		r.val   = val;
		r.sat   = sat;
		return r;
	endfunction

	// point mix: rails, zero, small values and full range
	function automatic coef_t pick_point();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3, 4, 5, 6: return coef_t'($urandom_range(1023)) - 16'sd512;
			default: return coef_t'($urandom);
		endcase
	endfunction

	// one input word; entered and left at a falling edge, valid left high
	task automatic send_word(input logic op, input coef_t pt, input logic typed,
			input logic signed [VAL_W-1:0] val, input logic sat);
		poly_result_t r;
		while (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		point    <= pt;
		do @(posedge clk); while (!in_ready);
		if (typed) begin
			r = '{value: val, power: '0, last: 1'b1, sat: sat};
			poly_results_due.push_back(r);
		end else begin
			compute_poly_results(op, pt);
		end
		if (op == OP_EVAL)
			n_eval_words++;
		else
			n_deriv_words++;
		@(negedge clk);
	endtask

	// stop sending and wait until every expected word has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (poly_results_due.size() != 0);
	endtask

	// one register write; only called with the unit idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg_write(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// new polynomial for a random phase
	task automatic load_random_poly(input int phase);
		int                style;
		logic [COEF_W-1:0] data;
		style = $urandom_range(2);
		data  = COEF_W'($urandom);
		data[DEG_W-1:0] = DEG_W'(phase % 8);
		write_reg(REG_DEGREE, data);
		for (int k = 0; k <= MAX_DEGREE; k++) begin
			if ($urandom_range(3) != 0) begin
				case (style)
					0: data = COEF_W'($urandom);
					1: data = COEF_W'($urandom_range(1023)) - 16'd512;
					default: begin
						case ($urandom_range(3))
							0: data = 16'h7FFF;
							1: data = 16'h8000;
							2: data = 16'h0000;
							default: data = 16'h0100;
						endcase
					end
				endcase
				write_reg(CFG_IDX_W'(REG_COEF0 + k), data);
			end
		end
		if ($urandom_range(3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(REG_BEYOND_LAST, REG_BEYOND_FIRST)),
				COEF_W'($urandom));
	endtask

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 17);
	end

	// result word checker
	always @(posedge clk) begin
		poly_result_t want;
		if (arst_n && out_valid && out_ready) begin
			n_result_words++;
			if (saturated === 1'b1)
				n_sat_words++;
			if (poly_results_due.size() == 0) begin
				$error("unexpected result word: value %0d term_power %0d", value, term_power);
				n_failures++;
			end else begin
				want = poly_results_due.pop_front();
				if (value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, value);
					n_failures++;
				end
				if (term_power !== want.power) begin
					$error("term_power: expected %0d, got %0d", want.power, term_power);
					n_failures++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					n_failures++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %0d, got %0d", want.sat, saturated);
					n_failures++;
				end
			end
		end
	end

	// stimulus
	initial begin
		logic op;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		opcode    = OP_EVAL;
		point     = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEGREE;
		cfg_data  = '0;
		calm      = 1'b0;
		cfg_degree = '0;
		foreach (cfg_coef[k])
			cfg_coef[k] = '0;

		// directed table
		plan.push_back(known_row(OP_EVAL, 16'sh7FFF, '0, 1'b0));
		plan.push_back(known_row(OP_DERIV, '0, '0, 1'b0));
		plan.push_back(cfg_row(REG_COEF0, 16'h8000));
		plan.push_back(known_row(OP_EVAL, 16'sh1234, -32'sd32768, 1'b0));
		// degree 7 is clamped to six
		plan.push_back(cfg_row(REG_DEGREE, 16'hFFFF));
		for (int k = 0; k <= MAX_DEGREE; k++)
			plan.push_back(cfg_row(CFG_IDX_W'(REG_COEF0 + k), 16'h7FFF));
		plan.push_back(known_row(OP_EVAL, 16'sh7FFF, 32'sh7FFFFFFF, 1'b1));
		plan.push_back(word_row(OP_EVAL, 16'sh8000));
		plan.push_back(known_row(OP_EVAL, '0, 32'sd32767, 1'b0));
		plan.push_back(word_row(OP_DERIV, '0));
		for (int k = 0; k <= MAX_DEGREE; k++)
			plan.push_back(cfg_row(CFG_IDX_W'(REG_COEF0 + k), 16'h8000));
		plan.push_back(word_row(OP_EVAL, 16'sh8000));
		plan.push_back(word_row(OP_EVAL, 16'sh7FFF));
		plan.push_back(word_row(OP_DERIV, 16'sh7FFF));
		// linear term of one lsb: floor rounding on negative products
		plan.push_back(cfg_row(REG_DEGREE, 16'h0001));
		plan.push_back(cfg_row(CFG_IDX_W'(REG_COEF0 + 1), 16'h0001));
		plan.push_back(cfg_row(REG_COEF0, 16'h0000));
		plan.push_back(word_row(OP_EVAL, 16'shFFFF));
		plan.push_back(word_row(OP_EVAL, 16'sh0100));
		plan.push_back(word_row(OP_DERIV, '0));
		// writes past the register list change nothing
		plan.push_back(cfg_row(REG_BEYOND_LAST, 16'hFFFF));
		plan.push_back(cfg_row(REG_BEYOND_FIRST, 16'h5555));
		plan.push_back(word_row(OP_EVAL, 16'shFFFF));
		plan.push_back(word_row(OP_DERIV, '0));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain_results();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_word(plan[i].op, plan[i].pt, plan[i].typed, plan[i].val, plan[i].sat);
			end
		end

		// random phases, each on a freshly loaded polynomial
		for (int phase = 0; phase < N_PHASES; phase++) begin
			drain_results();
			calm = (phase >= 4 && phase <= 6);
			load_random_poly(phase);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (phase == 2 && n == WORDS_PER_PHASE / 2)
					drain_results();
				op = ($urandom_range(99) < 25) ? OP_DERIV : OP_EVAL;
				send_word(op, pick_point(), 1'b0, '0, 1'b0);
			end
		end

		// quiet tail so that any extra result word is caught
		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d evaluate and %0d derivative words over %0d polynomials",
			n_eval_words, n_deriv_words, N_PHASES);
		$display("checked %0d result words, %0d of them saturated",
			n_result_words, n_sat_words);
		if (n_failures == 0)
			$display("tb_polynomial_eval_and_derivative_unit: PASS");
		else
			$display("tb_polynomial_eval_and_derivative_unit: FAIL");
		$finish;
	end

endmodule

/* files.f */
sv/pev_pkg.sv
sv/pev_front.sv
sv/pev_issue.sv
sv/pev_pipe.sv
sv/polynomial_eval_and_derivative_unit.sv
sv/pev_checker.sv
tb/tb_polynomial_eval_and_derivative_unit.sv
